>>> rtl/core/mpfd_pkg.sv
// Shared types, constants and font table for the page framebuffer draw core.
// No dependencies.
package mpfd_pkg;

    localparam int DEF_PANEL_WIDTH  = 128;
    localparam int DEF_PANEL_HEIGHT = 64;
    localparam int DEF_DIGIT_COUNT  = 3;
    localparam int STORE_DEPTH      = 1024;
    localparam int ADDR_W           = 10;

    localparam logic [2:0] REQ_CLEAR = 3'd0;
    localparam logic [2:0] REQ_PIXEL = 3'd1;
    localparam logic [2:0] REQ_RECT  = 3'd2;
    localparam logic [2:0] REQ_NUM   = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIPE,
        ST_DIGITS,
        ST_PLOT_SETUP,
        ST_RMW_READ,
        ST_RMW_WAIT,
        ST_RMW_WRITE,
        ST_STEP,
        ST_READ_WAIT,
        ST_READ_DONE,
        ST_DONE,
        ST_BOOT,
        ST_BOOT_WIPE
    } mpfd_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture request fields
        logic boot;       // zero the ink for the power-up sweep
        logic wipe_init;  // start clear sweep
        logic wipe_step;  // write one byte of the sweep, advance
        logic digit_step; // peel one decimal digit
        logic plot_init;  // set first pixel of the walk
        logic rd_pix;     // issue read of current pixel byte
        logic wr_pix;     // write modified byte
        logic adv;        // advance to next pixel of the walk
        logic rd_idx;     // issue read at read_index
        logic cap_read;   // capture read data into result
        logic clr_res;    // zero the result
    } mpfd_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [2:0] req;
        logic wipe_last;
        logic digits_done;
        logic walk_empty;
        logic walk_last;
        logic pix_ok;
    } mpfd_sts_t;

    function automatic logic [4:0] glyph_col(input logic [3:0] d, input logic [1:0] c);
        logic [14:0] g;
        unique case (d)
            4'd0: g = {5'h1F, 5'h11, 5'h1F};
            4'd1: g = {5'h1F, 5'h00, 5'h00};
            4'd2: g = {5'h17, 5'h15, 5'h1D};
            4'd3: g = {5'h1F, 5'h15, 5'h15};
            4'd4: g = {5'h1F, 5'h04, 5'h07};
            4'd5: g = {5'h1D, 5'h15, 5'h17};
            4'd6: g = {5'h1D, 5'h15, 5'h1F};
            4'd7: g = {5'h1F, 5'h01, 5'h01};
            4'd8: g = {5'h1F, 5'h15, 5'h1F};
            4'd9: g = {5'h1F, 5'h15, 5'h17};
            default: g = '0;
        endcase
        case (c)
            2'd0: glyph_col = g[4:0];
            2'd1: glyph_col = g[9:5];
            2'd2: glyph_col = g[14:10];
            default: glyph_col = '0;
        endcase
    endfunction

endpackage

>>> rtl/core/mpfd_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module mpfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end
endmodule

>>> rtl/core/mpfd_ctrl.sv
// Controller state machine for the draw core.
// Depends on mpfd_pkg.
module mpfd_ctrl
    import mpfd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  mpfd_sts_t sts,
    output mpfd_cmd_t cmd
);
    mpfd_state_t state_reg, state_next;
    logic        mv_reg, mv_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_BOOT;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    assign m_valid = mv_reg;
    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;

    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg;
        cmd        = '0;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            ST_BOOT: begin
                cmd.boot      = 1'b1;
                cmd.wipe_init = 1'b1;
                state_next    = ST_BOOT_WIPE;
            end
            ST_BOOT_WIPE: begin
                cmd.wipe_step = 1'b1;
                if (sts.wipe_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && !mv_reg) begin
                    cmd.load    = 1'b1;
                    cmd.clr_res = 1'b1;
                    unique case (sts.req) inside
                        REQ_CLEAR: begin
                            cmd.wipe_init = 1'b1;
                            state_next    = ST_WIPE;
                        end
                        REQ_PIXEL, REQ_RECT: state_next = ST_PLOT_SETUP;
                        REQ_NUM:  state_next = ST_DIGITS;
                        REQ_READ: state_next = ST_READ_WAIT;
                        default:  state_next = ST_DONE;
                    endcase
                    if (sts.req == REQ_READ) begin
                        cmd.rd_idx = 1'b1;
                    end
                end
            end
            ST_WIPE: begin
                cmd.wipe_step = 1'b1;
                if (sts.wipe_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DIGITS: begin
                cmd.digit_step = 1'b1;
                if (sts.digits_done) begin
                    state_next = ST_PLOT_SETUP;
                end
            end
            ST_PLOT_SETUP: begin
                cmd.plot_init = 1'b1;
                state_next    = ST_RMW_READ;
            end
            ST_RMW_READ: begin
                if (sts.walk_empty) begin
                    state_next = ST_DONE;
                end else if (sts.pix_ok) begin
                    cmd.rd_pix = 1'b1;
                    state_next = ST_RMW_WAIT;
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_RMW_WAIT: state_next = ST_RMW_WRITE;
            ST_RMW_WRITE: begin
                cmd.wr_pix = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (sts.walk_last) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.adv    = 1'b1;
                    state_next = ST_RMW_READ;
                end
            end
            ST_READ_WAIT: state_next = ST_READ_DONE;
            ST_READ_DONE: begin
                cmd.cap_read = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                mv_next    = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

>>> rtl/core/mpfd_dp.sv
// Datapath: request registers, pixel walker, digit splitter, frame store.
// Depends on mpfd_pkg and mpfd_ram.
module mpfd_dp
    import mpfd_pkg::*;
#(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT,
    parameter int DIGIT_COUNT  = DEF_DIGIT_COUNT
) (
    input  logic        aclk,
    input  mpfd_cmd_t   cmd,
    output mpfd_sts_t   sts,
    input  logic [2:0]  s_req_type,
    input  logic [7:0]  s_x_pos,
    input  logic [7:0]  s_y_pos,
    input  logic [7:0]  s_rect_width,
    input  logic [7:0]  s_rect_height,
    input  logic [7:0]  s_number_value,
    input  logic        s_ink,
    input  logic [9:0]  s_read_index,
    output logic [7:0]  m_read_data,
    output logic        m_read_valid
);
    localparam logic [7:0] PW1 = 8'(PANEL_WIDTH - 1);
    localparam logic [7:0] PH1 = 8'(PANEL_HEIGHT - 1);
    localparam logic [7:0] LSD_OFS = 8'(4 * (DIGIT_COUNT - 1));

    logic [2:0]  req_reg;
    logic [7:0]  x_reg, y_reg, xl_reg, yl_reg, val_reg;
    logic        ink_reg;
    logic [3:0]  dig_reg [DIGIT_COUNT];
    logic [1:0]  dcnt_reg;   // digits extracted
    logic [7:0]  col_reg, row_reg;
    logic [1:0]  gc_reg;     // glyph column
    logic [2:0]  gr_reg;     // glyph row
    logic [1:0]  k_reg;      // digit being drawn
    logic [7:0]  dx_reg;     // digit origin column
    logic [ADDR_W-1:0] wipe_reg;
    logic [7:0]  rd_data_reg;
    logic        rd_valid_reg;

    logic [7:0]  ram_q, ram_wd;
    logic [ADDR_W-1:0] ram_addr, pix_addr;
    logic        ram_we, ram_re;
    logic [7:0]  xl_w, yl_w;
    logic [8:0]  sx, sy;
    logic [4:0]  gcol;
    logic        is_num, in_panel;
    logic [7:0]  pc, pr;
    logic [7:0]  quo10;

    // wrapped, clamped rectangle ends
    assign sx   = 9'(s_x_pos) + 9'(s_rect_width);
    assign sy   = 9'(s_y_pos) + 9'(s_rect_height);
    assign xl_w = (sx[7:0] > PW1) ? PW1 : sx[7:0];
    assign yl_w = (sy[7:0] > PH1) ? PH1 : sy[7:0];

    // divide by ten with a reciprocal multiply, exact for 8-bit values
    assign quo10 = 8'((16'(val_reg) * 16'd205) >> 11);

    assign is_num = (req_reg == REQ_NUM);
    assign gcol   = glyph_col(dig_reg[k_reg], gc_reg);
    assign pc     = is_num ? 8'(dx_reg + 8'(gc_reg)) : col_reg;
    assign pr     = is_num ? 8'(y_reg + 8'(gr_reg)) : row_reg;
    assign in_panel = (pc <= PW1) && (pr <= PH1);
    assign pix_addr = ADDR_W'(32'(pr >> 3) * 32'(PANEL_WIDTH) + 32'(pc));

    always_comb begin
        sts.req         = s_req_type;
        sts.wipe_last   = (wipe_reg == ADDR_W'(STORE_DEPTH - 1));
        sts.digits_done = (val_reg == 8'd0) || (32'(dcnt_reg) == DIGIT_COUNT);
        // empty walk: rectangle inverted, no digit fits, or number off panel
        if (req_reg == REQ_RECT) begin
            sts.walk_empty = (xl_reg < x_reg) || (yl_reg < y_reg);
        end else if (is_num) begin
            sts.walk_empty = (y_reg > PH1) || (32'(k_reg) >= 32'(dcnt_reg))
                || (9'(dx_reg) + 9'd3 > 9'(PW1));
        end else begin
            sts.walk_empty = 1'b0;
        end
        sts.pix_ok = in_panel && (!is_num || gcol[gr_reg]);
        if (req_reg == REQ_PIXEL) begin
            sts.walk_last = 1'b1;
        end else if (req_reg == REQ_RECT) begin
            sts.walk_last = (col_reg == xl_reg) && (row_reg == yl_reg);
        end else begin
            sts.walk_last = (gr_reg == 3'd4) && (gc_reg == 2'd2)
                && (32'(k_reg) + 1 >= 32'(dcnt_reg));
        end
    end

    always_comb begin
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        ram_addr = pix_addr;
        ram_wd   = ink_reg ? (ram_q | (8'd1 << pr[2:0])) : (ram_q & ~(8'd1 << pr[2:0]));
        if (cmd.wipe_step) begin
            ram_we   = 1'b1;
            ram_addr = wipe_reg;
            ram_wd   = {8{ink_reg}};
        end else if (cmd.wr_pix) begin
            ram_we = 1'b1;
        end else if (cmd.rd_pix) begin
            ram_re = 1'b1;
        end else if (cmd.rd_idx) begin
            ram_re   = 1'b1;
            ram_addr = s_read_index;
        end
    end

    mpfd_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wd),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= s_req_type;
            x_reg    <= s_x_pos;
            y_reg    <= s_y_pos;
            xl_reg   <= xl_w;
            yl_reg   <= yl_w;
            val_reg  <= s_number_value;
            ink_reg  <= s_ink;
            dcnt_reg <= '0;
        end
        if (cmd.boot) begin
            ink_reg <= 1'b0;
        end
        if (cmd.clr_res) begin
            rd_data_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end
        if (cmd.wipe_init) begin
            wipe_reg <= '0;
        end
        if (cmd.wipe_step) begin
            wipe_reg <= ADDR_W'(wipe_reg + 1'b1);
        end
        // zero still draws one digit
        if (cmd.digit_step && (!sts.digits_done || dcnt_reg == 2'd0)) begin
            dig_reg[dcnt_reg] <= 4'(val_reg - 8'(quo10 * 8'd10));
            val_reg           <= quo10;
            dcnt_reg          <= 2'(dcnt_reg + 1'b1);
        end
        if (cmd.plot_init) begin
            col_reg <= x_reg;
            row_reg <= y_reg;
            gc_reg  <= '0;
            gr_reg  <= '0;
            k_reg   <= '0;
            dx_reg  <= 8'(x_reg + LSD_OFS);
        end
        if (cmd.adv) begin
            if (req_reg == REQ_RECT) begin
                if (col_reg == xl_reg) begin
                    col_reg <= x_reg;
                    row_reg <= 8'(row_reg + 1'b1);
                end else begin
                    col_reg <= 8'(col_reg + 1'b1);
                end
            end else if (gr_reg != 3'd4) begin
                gr_reg <= 3'(gr_reg + 1'b1);
            end else begin
                gr_reg <= '0;
                if (gc_reg != 2'd2) begin
                    gc_reg <= 2'(gc_reg + 1'b1);
                end else begin
                    gc_reg <= '0;
                    k_reg  <= 2'(k_reg + 1'b1);
                    dx_reg <= 8'(dx_reg - 8'd4);
                end
            end
        end
        if (cmd.cap_read) begin
            rd_data_reg  <= ram_q;
            rd_valid_reg <= 1'b1;
        end
    end

    assign m_read_data  = rd_data_reg;
    assign m_read_valid = rd_valid_reg;
endmodule

>>> rtl/core/mono_page_framebuffer_draw_core.sv
// Page-organized monochrome frame store drawing engine (1024 x 8 store).
// A read fetches one stored byte, a clear sweeps the whole store, and pixel, rectangle
// and number requests read-modify-write each drawn dot; a number first splits its
// digits, and a clipped pixel or a dark glyph dot is passed over without a write.
// One request at a time: the next transfer in comes the cycle after the result transfer.
// Reset (aresetn low, synchronous) clears control, then a sweep zeroes the store.
module mono_page_framebuffer_draw_core
    import mpfd_pkg::*;
#(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT,
    parameter int DIGIT_COUNT  = DEF_DIGIT_COUNT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_req_type,
    input  logic [7:0] s_x_pos,
    input  logic [7:0] s_y_pos,
    input  logic [7:0] s_rect_width,
    input  logic [7:0] s_rect_height,
    input  logic [7:0] s_number_value,
    input  logic       s_ink,
    input  logic [9:0] s_read_index,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_read_valid
);
    mpfd_cmd_t cmd;
    mpfd_sts_t sts;

    // Sequencer: one transfer in, a sweep, a read or a read-modify-write pixel walk, one out
    mpfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mpfd_dp #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .DIGIT_COUNT  (DIGIT_COUNT)
    ) u_dp (
        .aclk           (aclk),
        .cmd            (cmd),
        .sts            (sts),
        .s_req_type     (s_req_type),
        .s_x_pos        (s_x_pos),
        .s_y_pos        (s_y_pos),
        .s_rect_width   (s_rect_width),
        .s_rect_height  (s_rect_height),
        .s_number_value (s_number_value),
        .s_ink          (s_ink),
        .s_read_index   (s_read_index),
        .m_read_data    (m_read_data),
        .m_read_valid   (m_read_valid)
    );
endmodule

>>> rtl/core/mpfd_checker.sv
// Port-level checker for the draw core, bound to the top level.
// Depends on nothing beyond the top-level ports.
module mpfd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_data,
    input logic       m_read_valid
);
    a_no_in_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data))
        else $error("result dropped");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_read_valid |-> m_read_data == 8'd0)
        else $error("non-read result not zero");
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid) else $error("result too early");
endmodule

bind mono_page_framebuffer_draw_core mpfd_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_read_data(m_read_data),
    .m_read_valid(m_read_valid)
);

>>> verif/mpfd_draw_checker.sv
// Result checker for the page framebuffer draw core: mirrors the frame store,
// predicts every result and compares it. Depends on mpfd_pkg.
module mpfd_draw_checker
    import mpfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [2:0] s_req_type,
    input  logic [7:0] s_x_pos,
    input  logic [7:0] s_y_pos,
    input  logic [7:0] s_rect_width,
    input  logic [7:0] s_rect_height,
    input  logic [7:0] s_number_value,
    input  logic       s_ink,
    input  logic [9:0] s_read_index,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_read_data,
    input  logic       m_read_valid,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       is_read;
    } readback_t;

    logic [7:0] shadow_store [STORE_DEPTH];
    readback_t  readback_q [$];
    int         mismatches;

    // Digit font: columns 0..2 in bits 14:10, 9:5, 4:0; top row in bit 0.
    function automatic logic [14:0] digit_font(input int d);
        case (d)
            0: return {5'h1F, 5'h11, 5'h1F};
            1: return {5'h00, 5'h00, 5'h1F};
            2: return {5'h1D, 5'h15, 5'h17};
            3: return {5'h15, 5'h15, 5'h1F};
            4: return {5'h07, 5'h04, 5'h1F};
            5: return {5'h17, 5'h15, 5'h1D};
            6: return {5'h1F, 5'h15, 5'h1D};
            7: return {5'h01, 5'h01, 5'h1F};
            8: return {5'h1F, 5'h15, 5'h1F};
            9: return {5'h17, 5'h15, 5'h1F};
            default: return '0;
        endcase
    endfunction

    function automatic void set_dot(input int col, input int row, input logic on);
        int addr;
        if (col >= DEF_PANEL_WIDTH || row >= DEF_PANEL_HEIGHT) return;
        addr = ((row / 8) * DEF_PANEL_WIDTH + col) % STORE_DEPTH;
        shadow_store[addr][row % 8] = on;
    endfunction

    function automatic void fill_box(input int x, input int y, input int w, input int h,
                                     input logic on);
        int xl, yl;
        yl = (y + h) % 256;
        xl = (x + w) % 256;
        if (yl >= DEF_PANEL_HEIGHT) yl = DEF_PANEL_HEIGHT - 1;
        if (xl >= DEF_PANEL_WIDTH) xl = DEF_PANEL_WIDTH - 1;
        for (int r = y; r <= yl; r++)
            for (int c = x; c <= xl; c++)
                set_dot(c, r, on);
    endfunction

    function automatic void draw_decimal(input int x, input int y, input int v,
                                         input logic on);
        int digits [DEF_DIGIT_COUNT];
        int count;
        int col;
        logic [14:0] font;
        count = 0;
        if (y >= DEF_PANEL_HEIGHT) return;
        do begin
            digits[count] = v % 10;
            v = v / 10;
            count++;
        end while (v != 0 && count < DEF_DIGIT_COUNT);
        col = (x + 4 * (DEF_DIGIT_COUNT - 1)) % 256;
        for (int k = 0; k < count && col + 3 < DEF_PANEL_WIDTH; k++) begin
            font = digit_font(digits[k]);
            for (int c = 0; c < 3; c++)
                for (int r = 0; r < 5; r++)
                    if (font[(2 - c) * 5 + r])
                        set_dot((col + c) % 256, (y + r) % 256, on);
            col = (col + 252) % 256;
        end
    endfunction

    always @(posedge aclk) begin
        readback_t got, want;
        if (!aresetn) begin
            foreach (shadow_store[i]) shadow_store[i] = '0;
            readback_q.delete();
            fail_count <= 0;
            mismatches = 0;
        end else begin
            // Predict at input transfer.
            if (s_valid && s_ready) begin
                want = '0;
                case (s_req_type)
                    REQ_CLEAR: foreach (shadow_store[i]) shadow_store[i] = {8{s_ink}};
                    REQ_PIXEL: set_dot(s_x_pos, s_y_pos, s_ink);
                    REQ_RECT:  fill_box(s_x_pos, s_y_pos, s_rect_width, s_rect_height, s_ink);
                    REQ_NUM:   draw_decimal(s_x_pos, s_y_pos, s_number_value, s_ink);
                    REQ_READ:  want = '{data: shadow_store[s_read_index], is_read: 1'b1};
                    default: ;
                endcase
                readback_q.push_back(want);
            end
            // Compare at result transfer.
            if (m_valid && m_ready) begin
                got = '{data: m_read_data, is_read: m_read_valid};
                if (readback_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("checker: result with nothing pending: data %h valid %b",
                                 got.data, got.is_read);
                end else begin
                    want = readback_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("checker: expected data %h valid %b, got data %h valid %b",
                                     want.data, want.is_read, got.data, got.is_read);
                    end
                end
            end
            fail_count <= mismatches;
        end
    end

    assign pending = readback_q.size();

endmodule

>>> verif/tb_mono_page_framebuffer_draw_core.sv
// Top-level testbench for mono_page_framebuffer_draw_core: drives requests,
// paces results and gives the verdict. Depends on mpfd_pkg and mpfd_draw_checker.
module tb_mono_page_framebuffer_draw_core;
    import mpfd_pkg::*;

    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;
    // Longest legal silence: a full-panel fill, about 8192 pixels.
    localparam int QUIET_LIMIT = 120000;
    localparam int RANDOM_ITEMS = 830;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [2:0] s_req_type = REQ_CLEAR;
    logic [7:0] s_x_pos = '0;
    logic [7:0] s_y_pos = '0;
    logic [7:0] s_rect_width = '0;
    logic [7:0] s_rect_height = '0;
    logic [7:0] s_number_value = '0;
    logic       s_ink = 1'b0;
    logic [9:0] s_read_index = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_read_data;
    logic       m_read_valid;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    bit pace_gaps = 1'b1;     // when low, neither side idles
    int drain_hold = 0;       // one-shot long hold-off for the result side

    always #6 aclk = ~aclk;

    mono_page_framebuffer_draw_core dut (.*);

    mpfd_draw_checker u_checker (.*);

    // Abort when no transfer of any kind has happened for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[mono_page_framebuffer_draw_core] ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        return pace_gaps ? $urandom_range(0, 14) : 0;
    endfunction

    function automatic logic [7:0] rand8();
        return 8'($urandom);
    endfunction

    function automatic logic [9:0] rand10();
        return 10'($urandom);
    endfunction

    function automatic logic rand1();
        return 1'($urandom);
    endfunction

    // Result side: hold ready low for a drawn gap, then wait for the transfer.
    // Never lower and raise ready in the same step.
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            gap = pick_gap();
            if (drain_hold > 0) begin
                gap = drain_hold;
                drain_hold = 0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Offer one request and hold it until the transfer.
    task automatic send_request(input logic [2:0] req, input logic [7:0] x, input logic [7:0] y,
                                input logic [7:0] w, input logic [7:0] h,
                                input logic [7:0] num, input logic on, input logic [9:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_req_type     <= req;
        s_x_pos        <= x;
        s_y_pos        <= y;
        s_rect_width   <= w;
        s_rect_height  <= h;
        s_number_value <= num;
        s_ink          <= on;
        s_read_index   <= idx;
        s_valid        <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic read_back(input logic [9:0] idx);
        send_request(REQ_READ, rand8(), rand8(), rand8(), rand8(), rand8(), rand1(), idx);
    endtask

    // Wait for every outstanding result, with valid low on the input side.
    task automatic drain_all();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    initial begin
        int pick;
        logic [7:0] rx, ry, rw, rh;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: check the reset contents, then a clear and single pixels at the edges.
        read_back(10'd700);
        send_request(REQ_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 10'd0);
        read_back(10'd0);
        send_request(REQ_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 10'd0);
        send_request(REQ_PIXEL, 8'd127, 8'd63, 8'd0, 8'd0, 8'd0, 1'b1, 10'd0);
        send_request(REQ_PIXEL, 8'd128, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 10'd0);
        send_request(REQ_PIXEL, 8'd0, 8'd64, 8'd0, 8'd0, 8'd0, 1'b1, 10'd0);
        send_request(REQ_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 10'd1023);
        read_back(10'd0);
        read_back(10'd1023);
        // Rectangle clamped at the right edge, and two whose ends wrap below their start.
        send_request(REQ_RECT, 8'd120, 8'd3, 8'd20, 8'd9, 8'd0, 1'b1, 10'd0);
        send_request(REQ_RECT, 8'd10, 8'd250, 8'd2, 8'd10, 8'd0, 1'b1, 10'd0);
        send_request(REQ_RECT, 8'd60, 8'd60, 8'd3, 8'd200, 8'd0, 1'b1, 10'd0);
        read_back(10'd127);
        // Numbers: one digit, all three, stop at the edge, off-panel top, wrapped column.
        send_request(REQ_NUM, 8'd0, 8'd0, 8'd0, 8'd0, 8'd7, 1'b1, 10'd0);
        send_request(REQ_NUM, 8'd20, 8'd16, 8'd0, 8'd0, 8'd255, 1'b1, 10'd0);
        send_request(REQ_NUM, 8'd40, 8'd24, 8'd0, 8'd0, 8'd0, 1'b1, 10'd0);
        send_request(REQ_NUM, 8'd118, 8'd8, 8'd0, 8'd0, 8'd128, 1'b1, 10'd0);
        send_request(REQ_NUM, 8'd250, 8'd30, 8'd0, 8'd0, 8'd99, 1'b1, 10'd0);
        send_request(REQ_NUM, 8'd5, 8'd64, 8'd0, 8'd0, 8'd123, 1'b1, 10'd0);
        send_request(REQ_NUM, 8'd5, 8'd62, 8'd0, 8'd0, 8'd88, 1'b0, 10'd0);
        read_back(10'd148);
        send_request(REQ_SPARE_LO, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 1'b1, 10'd5);
        send_request(REQ_SPARE_HI, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 1'b1, 10'd5);
        send_request(REQ_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 10'd0);
        read_back(10'd517);

        // Sender pauses until all results are in.
        drain_all();

        // Receiver holds off long while reads keep coming, so the input stalls.
        drain_hold = 300;
        for (int i = 0; i < 12; i++) read_back(rand10());

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 200 == 100) pace_gaps = 1'b0;
            if (i % 200 == 160) pace_gaps = 1'b1;
            pick = $urandom_range(0, 99);
            rx = (pick % 2) ? 8'($urandom_range(0, 135)) : rand8();
            ry = (pick % 3) ? 8'($urandom_range(0, 70)) : rand8();
            if (pick < 2)
                send_request(REQ_CLEAR, rand8(), rand8(), rand8(), rand8(), rand8(),
                             rand1(), rand10());
            else if (pick < 30)
                send_request(REQ_PIXEL, rx, ry, rand8(), rand8(), rand8(), rand1(),
                             rand10());
            else if (pick < 50) begin
                // Mostly small boxes; occasionally a wide strip or a fully random one.
                rw = 8'($urandom_range(0, 7));
                rh = 8'($urandom_range(0, 7));
                if ($urandom_range(0, 9) == 0) begin
                    rw = rand8();
                    rh = 8'($urandom_range(0, 3));
                end
                if ($urandom_range(0, 99) == 0) begin
                    rw = rand8();
                    rh = rand8();
                end
                send_request(REQ_RECT, rx, ry, rw, rh, rand8(), rand1(), rand10());
            end else if (pick < 65)
                send_request(REQ_NUM, rx, ry, rand8(), rand8(), rand8(), rand1(),
                             rand10());
            else if (pick < 97)
                read_back(rand10());
            else
                send_request(3'($urandom_range(32'(REQ_SPARE_LO), 32'(REQ_SPARE_HI))),
                             rand8(), rand8(), rand8(), rand8(), rand8(), rand1(), rand10());
        end

        drain_all();
        repeat (50) @(negedge aclk);
        if (fail_count == 0)
            $display("[mono_page_framebuffer_draw_core] OK");
        else
            $display("[mono_page_framebuffer_draw_core] ERROR");
        $finish;
    end

endmodule
